### hw/rtl/bta_pkg.sv
package bta_pkg;

  // function codes of an input beat
  localparam logic [1:0] FUNC_USE   = 2'd0;
  localparam logic [1:0] FUNC_FREE  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  // fixed field widths
  localparam int unsigned FuncW = 2;
  localparam int unsigned SlotW = 11;

  // reciprocal divide by the word size: pos * RECIP >> RECIP_SHIFT
  localparam int unsigned RecipShift = 20;
  localparam int unsigned RecipW     = 18;
  localparam int unsigned ProdW      = SlotW + RecipW;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;       // latch the accepted beat
    logic div;        // first step of the word/bit split
    logic addr;       // correction step, word and bit registered
    logic rd_mod;     // read the addressed word
    logic wr_mod;     // write back the modified word, update count
    logic clr_step;   // write one zero word of the clearing sweep
    logic scan_start; // restart the find-first-free scan
    logic scan_step;  // one step of the scan
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic item_bad;   // mark with an out-of-range slot number
    logic item_mark;  // mark used or mark free
    logic item_clear; // clear all slots
    logic clr_last;   // sweep is at the last word
    logic scan_done;  // scan found a free slot or ran out of words
  } status_t;

endpackage

### hw/rtl/bta_ctrl.sv
module bta_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  bta_pkg::status_t status_i,
  output bta_pkg::cmd_t    cmd_o,
  output logic             busy,
  output logic             done_o
);

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DECODE,
    ST_ADDR,
    ST_READ,
    ST_MODIFY,
    ST_CLEAR,
    ST_SCAN_START,
    ST_SCAN
  } state_e;

  state_e state_q, state_d;
  logic   busy_q;
  logic   done_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INIT: begin
        if (status_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        priority if (status_i.item_clear) state_d = ST_CLEAR;
        else if (status_i.item_mark && !status_i.item_bad) state_d = ST_ADDR;
        else state_d = ST_SCAN_START;
      end
      ST_ADDR:       state_d = ST_READ;
      ST_READ:       state_d = ST_MODIFY;
      ST_MODIFY:     state_d = ST_SCAN_START;
      ST_CLEAR: begin
        if (status_i.clr_last) state_d = ST_SCAN_START;
      end
      ST_SCAN_START: state_d = ST_SCAN;
      ST_SCAN: begin
        if (status_i.scan_done) state_d = ST_IDLE;
      end
      default:       state_d = ST_IDLE;
    endcase
  end

  // commands decoded from the state
  always_comb begin
    cmd_o            = '0;
    cmd_o.load       = (state_q == ST_IDLE) && start;
    cmd_o.div        = (state_q == ST_DECODE);
    cmd_o.addr       = (state_q == ST_ADDR);
    cmd_o.rd_mod     = (state_q == ST_READ);
    cmd_o.wr_mod     = (state_q == ST_MODIFY);
    cmd_o.clr_step   = (state_q == ST_INIT) || (state_q == ST_CLEAR);
    cmd_o.scan_start = (state_q == ST_SCAN_START);
    cmd_o.scan_step  = (state_q == ST_SCAN);
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      busy_q  <= 1'b1;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= (state_d != ST_IDLE);
      done_q  <= (state_q == ST_SCAN) && status_i.scan_done;
    end
  end

  assign busy   = busy_q;
  assign done_o = done_q;

endmodule

### hw/rtl/bta_dp.sv
module bta_dp #(
  parameter int unsigned NUM_TILES = 1024,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  bta_pkg::cmd_t                cmd_i,
  output bta_pkg::status_t             status_o,
  input  logic [bta_pkg::FuncW-1:0]    func_i,
  input  logic [bta_pkg::SlotW-1:0]    tile_index_i,
  output logic [bta_pkg::SlotW-1:0]    first_free_o,
  output logic [bta_pkg::SlotW-1:0]    used_count_o,
  output logic                         index_error_o
);

  localparam int unsigned MapWords = (NUM_TILES + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned AW       = (MapWords > 1) ? $clog2(MapWords) : 1;
  localparam int unsigned BW       = $clog2(WORD_BITS);
  localparam int unsigned CW       = $clog2(NUM_TILES + 1);
  localparam int unsigned LastBits = NUM_TILES - (MapWords - 1) * WORD_BITS;
  localparam int unsigned Recip    = (1 << bta_pkg::RecipShift) / WORD_BITS;
  localparam int unsigned SW       = bta_pkg::SlotW;
  localparam logic [AW-1:0] LastWord = AW'(MapWords - 1);

  // bitmap memory
  logic [WORD_BITS-1:0] mem_q [MapWords];

  // latched beat
  logic [bta_pkg::FuncW-1:0] func_q;
  logic [SW-1:0]             idx_q;
  logic                      err_q;

  // word/bit split
  logic [SW-1:0]             pos;
  logic [bta_pkg::ProdW-1:0] prod;
  logic [SW-1:0]             q_est_q;
  logic [SW-1:0]             rem;
  logic [AW-1:0]             word_q;
  logic [BW-1:0]             bit_q;

  // read port
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic [WORD_BITS-1:0] rd_data_q;
  logic [AW-1:0]        rd_tag_q;
  logic                 rd_vld_q;

  // write port
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [WORD_BITS-1:0] wr_data;

  // sweep, count, scan
  logic [AW-1:0]        sweep_q;
  logic [CW-1:0]        cnt_q;
  logic [AW-1:0]        scan_addr_q;
  logic                 issued_all_q;
  logic                 scan_issue;
  logic [WORD_BITS-1:0] valid_mask;
  logic [WORD_BITS-1:0] free_vec;
  logic [WORD_BITS-1:0] lowest;
  logic [BW-1:0]        enc;
  logic                 scan_eval;
  logic                 scan_hit;
  logic                 scan_miss;
  logic [CW-1:0]        hit_slot;
  logic [CW-1:0]        ff_q;
  logic                 was_used;
  logic                 is_use;

  // beat latch and range check
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= func_i;
      idx_q  <= tile_index_i;
      err_q  <= ((func_i == bta_pkg::FUNC_USE) || (func_i == bta_pkg::FUNC_FREE)) &&
                ((tile_index_i == '0) || ({2'b00, tile_index_i} > (SW + 2)'(NUM_TILES)));
    end
  end

  // quotient estimate by reciprocal, then one correction
  assign pos  = idx_q - SW'(1);
  assign prod = bta_pkg::ProdW'(pos) * bta_pkg::ProdW'(Recip);
  assign rem  = pos - SW'(q_est_q * WORD_BITS);

  always_ff @(posedge clk_i) begin
    if (cmd_i.div) begin
      q_est_q <= SW'(prod >> bta_pkg::RecipShift);
    end
    if (cmd_i.addr) begin
      if (rem >= SW'(WORD_BITS)) begin
        word_q <= AW'(q_est_q + SW'(1));
        bit_q  <= BW'(rem - SW'(WORD_BITS));
      end else begin
        word_q <= AW'(q_est_q);
        bit_q  <= BW'(rem);
      end
    end
  end

  // read and write port selection
  assign scan_issue = cmd_i.scan_step && !issued_all_q;
  assign rd_en      = cmd_i.rd_mod || scan_issue;
  assign rd_addr    = cmd_i.rd_mod ? word_q : scan_addr_q;

  assign is_use   = (func_q == bta_pkg::FUNC_USE);
  assign was_used = rd_data_q[bit_q];
  assign wr_en    = cmd_i.clr_step || cmd_i.wr_mod;
  assign wr_addr  = cmd_i.clr_step ? sweep_q : word_q;

  always_comb begin
    wr_data = rd_data_q;
    if (cmd_i.clr_step) begin
      wr_data = '0;
    end else begin
      wr_data[bit_q] = is_use;
    end
  end

  // bitmap memory access
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
      rd_tag_q  <= rd_addr;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q     <= 1'b0;
      sweep_q      <= '0;
      cnt_q        <= '0;
      scan_addr_q  <= '0;
      issued_all_q <= 1'b0;
    end else begin
      rd_vld_q <= rd_en;
      if (cmd_i.load) begin
        sweep_q <= '0;
      end else if (cmd_i.clr_step) begin
        sweep_q <= sweep_q + AW'(1);
      end
      if (cmd_i.clr_step) begin
        cnt_q <= '0;
      end else if (cmd_i.wr_mod) begin
        if (is_use && !was_used) begin
          cnt_q <= cnt_q + CW'(1);
        end else if (!is_use && was_used) begin
          cnt_q <= cnt_q - CW'(1);
        end
      end
      if (cmd_i.scan_start) begin
        scan_addr_q  <= '0;
        issued_all_q <= 1'b0;
      end else if (scan_issue) begin
        if (scan_addr_q == LastWord) begin
          issued_all_q <= 1'b1;
        end else begin
          scan_addr_q <= scan_addr_q + AW'(1);
        end
      end
    end
  end

  // slots past the end of the last word count as used
  always_comb begin
    valid_mask = '1;
    if (rd_tag_q == LastWord) begin
      for (int unsigned b = 0; b < WORD_BITS; b++) begin
        valid_mask[b] = (b < LastBits);
      end
    end
  end

  // lowest free bit of the word just read
  assign free_vec = ~rd_data_q & valid_mask;
  assign lowest   = free_vec & (~free_vec + WORD_BITS'(1));

  always_comb begin
    enc = '0;
    for (int unsigned b = 0; b < WORD_BITS; b++) begin
      enc = enc | (lowest[b] ? BW'(b) : BW'(0));
    end
  end

  assign scan_eval = cmd_i.scan_step && rd_vld_q;
  assign scan_hit  = scan_eval && (free_vec != '0);
  assign scan_miss = scan_eval && (free_vec == '0) && (rd_tag_q == LastWord);
  assign hit_slot  = CW'(rd_tag_q * WORD_BITS) + CW'(enc) + CW'(1);

  // scan result
  always_ff @(posedge clk_i) begin
    if (scan_hit) begin
      ff_q <= hit_slot;
    end else if (scan_miss) begin
      ff_q <= '0;
    end
  end

  // status to the controller
  always_comb begin
    status_o            = '0;
    status_o.item_bad   = err_q;
    status_o.item_mark  = (func_q == bta_pkg::FUNC_USE) || (func_q == bta_pkg::FUNC_FREE);
    status_o.item_clear = (func_q == bta_pkg::FUNC_CLEAR);
    status_o.clr_last   = (sweep_q == LastWord);
    status_o.scan_done  = scan_hit || scan_miss;
  end

  assign first_free_o  = SW'(ff_q);
  assign used_count_o  = SW'(cnt_q);
  assign index_error_o = err_q;

endmodule

### hw/rtl/bitmap_tile_allocator.sv
// Tile slot allocator over a used/free bitmap, slots numbered 1..NUM_TILES.
// Command channel: a beat (func_i, tile_index_i) is taken at a rising edge
// with start high and busy low. func_i marks one slot used, marks one slot
// free, or clears the map; a mark with slot 0 or above NUM_TILES is dropped.
// Result channel: done_o is high for exactly one cycle per command, with
// first_free_o (lowest free slot, 0 if none), used_count_o and index_error_o
// valid in that cycle. The receiver cannot stall, so the result must be
// taken in that cycle; busy falls with the strobe.
// Sequence: a mark splits its slot into word and bit, then reads and writes
// back that word; a dropped beat skips these steps, and a clear first writes
// every word of the map to zero. Every command ends in the find-first-free
// scan, one bitmap word a cycle through the single read port of the map
// memory, which stops at the word holding the lowest free slot or after the
// last word. One command is in flight at a time.
// Reset: after rst_ni is released, a clearing pass writes the MapWords words
// of the map, one a cycle; busy stays high during the pass, and
// the map then starts all free with a used count of zero.
module bitmap_tile_allocator #(
  parameter int unsigned NUM_TILES = 1024,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [bta_pkg::FuncW-1:0] func_i,
  input  logic [bta_pkg::SlotW-1:0] tile_index_i,
  output logic                      done_o,
  output logic [bta_pkg::SlotW-1:0] first_free_o,
  output logic [bta_pkg::SlotW-1:0] used_count_o,
  output logic                      index_error_o
);

  bta_pkg::cmd_t    cmd;
  bta_pkg::status_t status;

  // sequencer
  bta_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy     (busy),
    .done_o   (done_o)
  );

  // bitmap, count and scan
  bta_dp #(
    .NUM_TILES (NUM_TILES),
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .func_i        (func_i),
    .tile_index_i  (tile_index_i),
    .first_free_o  (first_free_o),
    .used_count_o  (used_count_o),
    .index_error_o (index_error_o)
  );

endmodule

### hw/rtl/bta_checker.sv
module bta_checker #(
  parameter int unsigned NUM_TILES = 1024
) (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      start,
  input logic                      busy,
  input logic                      done_o,
  input logic [bta_pkg::SlotW-1:0] first_free_o,
  input logic [bta_pkg::SlotW-1:0] used_count_o
);

  // an accepted command keeps the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted beat did not raise busy");

  // a result beat only closes a busy period
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result beat without a command in flight");

  // one result beat per command, never two in a row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held longer than one cycle");

  // reported slot and count stay inside the map
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ({2'b00, first_free_o} <= (bta_pkg::SlotW + 2)'(NUM_TILES)) &&
               ({2'b00, used_count_o} <= (bta_pkg::SlotW + 2)'(NUM_TILES)))
    else $error("result slot or count beyond the map");

endmodule

bind bitmap_tile_allocator bta_checker #(
  .NUM_TILES (NUM_TILES)
) u_bta_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .done_o       (done_o),
  .first_free_o (first_free_o),
  .used_count_o (used_count_o)
);

### sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned NumTiles  = 1024;
  localparam int unsigned WordBits  = 32;
  localparam int unsigned FuncW     = bta_pkg::FuncW;
  localparam int unsigned SlotW     = bta_pkg::SlotW;
  localparam logic [1:0]  FuncRsvd  = 2'd3;
  localparam int unsigned FillBeats = 1150;
  localparam int unsigned MixBeats  = 650;
  localparam int unsigned StallMax  = 2000;
  localparam int unsigned DirRows   = 20;

  // status reported after every command beat
  typedef struct packed {
    logic [SlotW-1:0] first_free;
    logic [SlotW-1:0] used_count;
    logic             index_error;
  } tile_status_t;

  // one row of the directed table
  typedef struct packed {
    logic [FuncW-1:0] fn;
    logic [SlotW-1:0] idx;
    logic             typed;
    tile_status_t     st;
  } dir_row_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start = 1'b0;
  logic [FuncW-1:0] func_i = bta_pkg::FUNC_USE;
  logic [SlotW-1:0] tile_index_i = '0;
  logic             busy;
  logic             done_o;
  logic [SlotW-1:0] first_free_o;
  logic [SlotW-1:0] used_count_o;
  logic             index_error_o;

  // predicted slot map and count
  bit           slot_used [1:NumTiles];
  int unsigned  used_cnt;
  tile_status_t last_status;
  tile_status_t pending_status [$];
  int unsigned  n_errors = 0;
  int unsigned  quiet_cycles = 0;
  bit           idle_on;

  bitmap_tile_allocator #(
    .NUM_TILES(NumTiles),
    .WORD_BITS(WordBits)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .func_i       (func_i),
    .tile_index_i (tile_index_i),
    .done_o       (done_o),
    .first_free_o (first_free_o),
    .used_count_o (used_count_o),
    .index_error_o(index_error_o)
  );

  always #6 clk_i = ~clk_i;

  // apply one command to the predicted map, return the status it reports
  function automatic tile_status_t next_tile_status(input logic [FuncW-1:0] fn,
                                                    input logic [SlotW-1:0] idx);
    tile_status_t st;
    st = '0;
    if (fn == bta_pkg::FUNC_USE || fn == bta_pkg::FUNC_FREE) begin
      if (idx == 0 || idx > NumTiles) begin
        st.index_error = 1'b1;
      end else if (fn == bta_pkg::FUNC_USE && !slot_used[idx]) begin
        slot_used[idx] = 1'b1;
        used_cnt++;
      end else if (fn == bta_pkg::FUNC_FREE && slot_used[idx]) begin
        slot_used[idx] = 1'b0;
        used_cnt--;
      end
    end else if (fn == bta_pkg::FUNC_CLEAR) begin
      foreach (slot_used[s]) slot_used[s] = 1'b0;
      used_cnt = 0;
    end
    // lowest free slot, zero when the map is full
    for (int s = 1; s <= NumTiles; s++) begin
      if (!slot_used[s]) begin
        st.first_free = SlotW'(s);
        break;
      end
    end
    st.used_count = SlotW'(used_cnt);
    return st;
  endfunction

  // drive one beat, wait for the handshake, queue its expected status
  task automatic issue_cmd(input logic [FuncW-1:0] fn, input logic [SlotW-1:0] idx,
                           input logic typed, input tile_status_t typed_st);
    tile_status_t st;
    if (idle_on && $urandom_range(99) < 11) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    start        <= 1'b1;
    func_i       <= fn;
    tile_index_i <= idx;
    do @(posedge clk_i); while (busy);
    st          = next_tile_status(fn, idx);
    last_status = st;
    pending_status.push_back(typed ? typed_st : st);
    @(negedge clk_i);
  endtask

  // random out-of-range mark index, slot 0 or above the map, for the error path
  function automatic logic [SlotW-1:0] bad_index();
    return ($urandom_range(1) == 0) ? SlotW'(0) : SlotW'($urandom_range(NumTiles + 1, 2047));
  endfunction

  // directed rows, starting from the empty map after reset
  dir_row_t dir_rows [DirRows] = '{
    '{bta_pkg::FUNC_USE,   11'd1,    1'b1, '{11'd2, 11'd1, 1'b0}},
    '{bta_pkg::FUNC_USE,   11'd0,    1'b1, '{11'd2, 11'd1, 1'b1}},
    '{bta_pkg::FUNC_FREE,  11'd0,    1'b1, '{11'd2, 11'd1, 1'b1}},
    '{bta_pkg::FUNC_USE,   11'd1025, 1'b1, '{11'd2, 11'd1, 1'b1}},
    '{bta_pkg::FUNC_FREE,  11'd2047, 1'b1, '{11'd2, 11'd1, 1'b1}},
    '{bta_pkg::FUNC_USE,   11'd1,    1'b0, '0},
    '{bta_pkg::FUNC_USE,   11'd2,    1'b0, '0},
    '{bta_pkg::FUNC_FREE,  11'd1,    1'b0, '0},
    '{bta_pkg::FUNC_FREE,  11'd1,    1'b0, '0},
    '{bta_pkg::FUNC_USE,   11'd1024, 1'b0, '0},
    '{bta_pkg::FUNC_USE,   11'd33,   1'b0, '0},
    '{bta_pkg::FUNC_USE,   11'd32,   1'b0, '0},
    '{FuncRsvd,            11'd2047, 1'b0, '0},
    '{FuncRsvd,            11'd0,    1'b0, '0},
    '{bta_pkg::FUNC_CLEAR, 11'd2047, 1'b1, '{11'd1, 11'd0, 1'b0}},
    '{bta_pkg::FUNC_USE,   11'd1024, 1'b1, '{11'd1, 11'd1, 1'b0}},
    '{bta_pkg::FUNC_FREE,  11'd1024, 1'b1, '{11'd1, 11'd0, 1'b0}},
    '{bta_pkg::FUNC_CLEAR, 11'd0,    1'b1, '{11'd1, 11'd0, 1'b0}},
    '{bta_pkg::FUNC_USE,   11'd1023, 1'b0, '0},
    '{bta_pkg::FUNC_FREE,  11'd1023, 1'b0, '0}
  };

  // stimulus
  initial begin
    logic [FuncW-1:0] fn;
    logic [SlotW-1:0] idx;
    int unsigned      pick;
    used_cnt = 0;
    idle_on  = 1'b1;
    foreach (slot_used[s]) slot_used[s] = 1'b0;
    last_status = '{11'd1, 11'd0, 1'b0};
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[r])
      issue_cmd(dir_rows[r].fn, dir_rows[r].idx, dir_rows[r].typed, dir_rows[r].st);

    // fill phase: mostly allocate the lowest free slot, with some noise, to fill the map
    for (int unsigned n = 0; n < FillBeats; n++) begin
      idle_on = !(n >= 400 && n < 800);
      pick    = $urandom_range(99);
      if (pick < 95) begin
        fn  = bta_pkg::FUNC_USE;
        idx = (last_status.first_free != 0) ? last_status.first_free
                                            : SlotW'($urandom_range(1, NumTiles));
      end else if (pick < 97) begin
        fn  = ($urandom_range(1) == 0) ? bta_pkg::FUNC_USE : bta_pkg::FUNC_FREE;
        idx = bad_index();
      end else if (pick < 98) begin
        fn  = FuncRsvd;
        idx = SlotW'($urandom_range(2047));
      end else begin
        fn  = bta_pkg::FUNC_USE;
        idx = SlotW'($urandom_range(1, NumTiles));
      end
      issue_cmd(fn, idx, 1'b0, '0);
    end

    // churn phase: allocate, release, occasional clear and noise
    idle_on = 1'b1;
    for (int unsigned n = 0; n < MixBeats; n++) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        fn  = bta_pkg::FUNC_USE;
        idx = (last_status.first_free != 0) ? last_status.first_free
                                            : SlotW'($urandom_range(1, NumTiles));
      end else if (pick < 75) begin
        fn  = bta_pkg::FUNC_FREE;
        idx = SlotW'($urandom_range(1, NumTiles));
      end else if (pick < 85) begin
        fn  = bta_pkg::FUNC_USE;
        idx = SlotW'($urandom_range(1, NumTiles));
      end else if (pick < 93) begin
        fn  = ($urandom_range(1) == 0) ? bta_pkg::FUNC_USE : bta_pkg::FUNC_FREE;
        idx = bad_index();
      end else if (pick < 98) begin
        fn  = FuncRsvd;
        idx = SlotW'($urandom_range(2047));
      end else begin
        fn  = bta_pkg::FUNC_CLEAR;
        idx = SlotW'($urandom_range(2047));
      end
      issue_cmd(fn, idx, 1'b0, '0);
    end
    start <= 1'b0;

    // drain, then let the block settle
    while (pending_status.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (n_errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // result checker, one beat per strobe
  always @(posedge clk_i) begin
    tile_status_t exp_st;
    if (rst_ni && done_o) begin
      if (pending_status.size() == 0) begin
        $error("result beat with no expected status");
        n_errors++;
      end else begin
        exp_st = pending_status.pop_front();
        if (first_free_o !== exp_st.first_free) begin
          $error("first_free: expected %0d, got %0d", exp_st.first_free, first_free_o);
          n_errors++;
        end
        if (used_count_o !== exp_st.used_count) begin
          $error("used_count: expected %0d, got %0d", exp_st.used_count, used_count_o);
          n_errors++;
        end
        if (index_error_o !== exp_st.index_error) begin
          $error("index_error: expected %0d, got %0d", exp_st.index_error, index_error_o);
          n_errors++;
        end
      end
    end
  end

  // cycles without any beat moving on either side
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  // watchdog
  initial begin
    while (quiet_cycles < StallMax) @(posedge clk_i);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### filelist.f
hw/rtl/bta_pkg.sv
hw/rtl/bta_ctrl.sv
hw/rtl/bta_dp.sv
hw/rtl/bitmap_tile_allocator.sv
hw/rtl/bta_checker.sv
sim/tb_top.sv
